/* hw/rtl/ffcd_pkg.sv */
// shared types, codes and defaults for the fifo feature cache directory
package ffcd_pkg;

    localparam int NODES_DEFAULT       = 65536;
    localparam int CACHE_SLOTS_DEFAULT = 4096;
    localparam int PARTITIONS_DEFAULT  = 16;

    localparam int NODE_W     = 16;
    localparam int PART_IN_W  = 5;
    localparam int PART_W     = 4;
    localparam int LIDX_W     = 16;
    localparam int SLOT_OUT_W = 12;
    localparam int SRC_W      = 2;
    localparam int SLOTS_W    = 13;
    localparam int MASK_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 13'd4096;
    localparam logic [MASK_W-1:0]  MASK_RESET  = 16'd0;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MASK   = 1'd1;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_LOAD    = 1'b1;

    localparam logic [SRC_W-1:0] SRC_HIT    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_LOCAL  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_REMOTE = 2'd2;
    localparam logic [SRC_W-1:0] SRC_SKIP   = 2'd3;

    typedef struct packed {
        logic clr_en;
        logic load_wr;
        logic capture;
        logic owner_lookup;
        logic evict;
        logic fill;
        logic out_short;
    } ffcd_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_hit;
        logic is_skip;
        logic out_free;
    } ffcd_status_t;

endpackage

/* hw/rtl/fifo_feature_cache_directory.sv */
// top level of the fifo feature cache directory
//
//   channel  handshake                 payload
//   in       in_valid / in_ready       func, node_id, partition_in, local_index_in
//   out      out_valid / out_ready     source, slot, partition_out, local_index_out,
//                                      evicted_valid, evicted_node
//   cfg      cfg_we                    cfg_idx, cfg_data
//
// a load is written as it is accepted; a request that hits or is skipped takes a
// registered map read and then its result, a fill takes a registered map read, an owner
// map read, an eviction write and a fill write since the node map has one write port and
// one read port; after reset a clearing pass empties the node map, partition
// store and slot owner table; in_ready stays low during it, config writes are taken as ever
// one transaction is in flight at a time; a finished result sits in the output
// register while out_ready is low and the next request waits only at its last step
module fifo_feature_cache_directory
    import ffcd_pkg::*;
#(
    parameter int NODES       = NODES_DEFAULT,
    parameter int CACHE_SLOTS = CACHE_SLOTS_DEFAULT,
    parameter int PARTITIONS  = PARTITIONS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [NODE_W-1:0]            node_id,
    input  logic signed [PART_IN_W-1:0]  partition_in,
    input  logic [LIDX_W-1:0]            local_index_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SRC_W-1:0]             source,
    output logic [SLOT_OUT_W-1:0]        slot,
    output logic [PART_W-1:0]            partition_out,
    output logic [LIDX_W-1:0]            local_index_out,
    output logic                         evicted_valid,
    output logic [NODE_W-1:0]            evicted_node
);

    ffcd_cmd_t    cmd;
    ffcd_status_t status;

    ffcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ffcd_datapath #(
        .NODES       (NODES),
        .CACHE_SLOTS (CACHE_SLOTS),
        .PARTITIONS  (PARTITIONS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .node_id         (node_id),
        .partition_in    (partition_in),
        .local_index_in  (local_index_in),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .source          (source),
        .slot            (slot),
        .partition_out   (partition_out),
        .local_index_out (local_index_out),
        .evicted_valid   (evicted_valid),
        .evicted_node    (evicted_node)
    );

endmodule

/* hw/rtl/ffcd_ctrl.sv */
// controller state machine for the cache directory
module ffcd_ctrl
    import ffcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         func,
    output logic         in_ready,
    input  ffcd_status_t status,
    output ffcd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_FILL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (status.is_hit || status.is_skip)
                begin
                    if (status.out_free)
                    begin
                        cmd.out_short = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.owner_lookup = 1'b1;
                    state_next       = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (status.out_free)
                begin
                    cmd.fill   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/ffcd_datapath.sv */
// directory memories, slot pointer, config registers and output register
module ffcd_datapath
    import ffcd_pkg::*;
#(
    parameter int NODES       = NODES_DEFAULT,
    parameter int CACHE_SLOTS = CACHE_SLOTS_DEFAULT,
    parameter int PARTITIONS  = PARTITIONS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic [NODE_W-1:0]            node_id,
    input  logic signed [PART_IN_W-1:0]  partition_in,
    input  logic [LIDX_W-1:0]            local_index_in,
    input  ffcd_cmd_t                    cmd,
    output ffcd_status_t                 status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SRC_W-1:0]             source,
    output logic [SLOT_OUT_W-1:0]        slot,
    output logic [PART_W-1:0]            partition_out,
    output logic [LIDX_W-1:0]            local_index_out,
    output logic                         evicted_valid,
    output logic [NODE_W-1:0]            evicted_node
);

    localparam int NODE_AW = $clog2(NODES);
    localparam int SLOT_AW = $clog2(CACHE_SLOTS);
    localparam int LIM_W   = SLOT_AW + 1;
    localparam int MAP_W   = SLOT_AW + 1;
    localparam int PENT_W  = PART_W + 1;

    logic [MAP_W-1:0]  map_mem   [NODES];
    logic [PENT_W-1:0] part_mem  [NODES];
    logic [LIDX_W-1:0] lidx_mem  [NODES];
    logic [NODE_W-1:0] owner_mem [CACHE_SLOTS];

    logic [SLOTS_W-1:0] slots_reg;
    logic [SLOTS_W-1:0] slots_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic [NODE_AW-1:0] clr_cnt_reg;
    logic [NODE_AW-1:0] clr_cnt_next;
    logic [SLOT_AW-1:0] next_slot_reg;
    logic [SLOT_AW-1:0] next_slot_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [NODE_W-1:0]  node_reg;
    logic               node_ok_reg;
    logic [SLOT_AW-1:0] cur_reg;
    logic [MAP_W-1:0]   map_rd_reg;
    logic [PENT_W-1:0]  part_rd_reg;
    logic [LIDX_W-1:0]  lidx_rd_reg;
    logic [NODE_W-1:0]  owner_rd_reg;
    logic               evict_reg;

    logic [SRC_W-1:0]      source_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [PART_W-1:0]     part_out_reg;
    logic [LIDX_W-1:0]     lidx_out_reg;
    logic                  ev_valid_reg;
    logic [NODE_W-1:0]     ev_node_reg;

    logic [LIM_W-1:0]   lim;
    logic [SLOT_AW-1:0] cur;
    logic [SLOT_AW:0]   cur_inc;
    logic [NODE_AW-1:0] in_idx;
    logic [NODE_AW-1:0] node_idx;
    logic [NODE_AW-1:0] owner_idx;
    logic               in_node_ok;
    logic               owner_ok;
    logic               part_ok;
    logic [PENT_W-1:0]  part_wdata;
    logic               map_we;
    logic [NODE_AW-1:0] map_waddr;
    logic [MAP_W-1:0]   map_wdata;
    logic [NODE_AW-1:0] map_raddr;
    logic               part_we;
    logic [NODE_AW-1:0] part_waddr;
    logic               out_pop;
    logic               out_free;

    assign in_idx     = NODE_AW'(node_id);
    assign node_idx   = NODE_AW'(node_reg);
    assign owner_idx  = NODE_AW'(owner_rd_reg);
    assign in_node_ok = (32'(node_id) < NODES);
    assign owner_ok   = (32'(owner_rd_reg) < NODES);
    assign part_ok    = !partition_in[PART_IN_W-1]
                        && (32'(partition_in[PART_W-1:0]) < PARTITIONS);
    assign part_wdata = part_ok ? {1'b1, partition_in[PART_W-1:0]} : '0;

    always_comb
    begin
        if (slots_reg == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (32'(slots_reg) > CACHE_SLOTS)
        begin
            lim = LIM_W'(CACHE_SLOTS);
        end
        else
        begin
            lim = LIM_W'(slots_reg);
        end
    end

    assign cur     = (LIM_W'(next_slot_reg) >= lim) ? '0 : next_slot_reg;
    assign cur_inc = {1'b0, cur_reg} + 1'b1;

    assign out_pop  = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign status.clr_last = (clr_cnt_reg == NODE_AW'(NODES - 1));
    assign status.is_hit   = node_ok_reg && map_rd_reg[SLOT_AW];
    assign status.is_skip  = !node_ok_reg || (!map_rd_reg[SLOT_AW] && !part_rd_reg[PART_W]);
    assign status.out_free = out_free;

    // map write port shared by clearing pass, eviction and fill
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = clr_cnt_reg;
        map_wdata = '0;
        if (cmd.clr_en)
        begin
            map_we = 1'b1;
        end
        else if (cmd.evict)
        begin
            map_we    = owner_ok && (map_rd_reg == {1'b1, cur_reg});
            map_waddr = owner_idx;
        end
        else if (cmd.fill)
        begin
            map_we    = 1'b1;
            map_waddr = node_idx;
            map_wdata = {1'b1, cur_reg};
        end
    end

    assign map_raddr  = cmd.capture ? in_idx : owner_idx;
    assign part_we    = cmd.clr_en || (cmd.load_wr && in_node_ok);
    assign part_waddr = cmd.clr_en ? clr_cnt_reg : in_idx;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.capture || cmd.owner_lookup)
        begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_we)
        begin
            part_mem[part_waddr] <= cmd.clr_en ? '0 : part_wdata;
        end
        if (cmd.capture)
        begin
            part_rd_reg <= part_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && in_node_ok)
        begin
            lidx_mem[in_idx] <= local_index_in;
        end
        if (cmd.capture)
        begin
            lidx_rd_reg <= lidx_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            owner_mem[SLOT_AW'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.fill)
        begin
            owner_mem[cur_reg] <= node_reg;
        end
        if (cmd.capture)
        begin
            owner_rd_reg <= owner_mem[cur];
        end
    end

    // transaction context and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            node_reg    <= node_id;
            node_ok_reg <= in_node_ok;
            cur_reg     <= cur;
        end
        if (cmd.evict)
        begin
            evict_reg <= owner_ok && (map_rd_reg == {1'b1, cur_reg});
        end
        if (cmd.out_short)
        begin
            source_reg   <= status.is_hit ? SRC_HIT : SRC_SKIP;
            slot_reg     <= status.is_hit ? SLOT_OUT_W'(map_rd_reg[SLOT_AW-1:0]) : '0;
            part_out_reg <= '0;
            lidx_out_reg <= '0;
            ev_valid_reg <= 1'b0;
            ev_node_reg  <= '0;
        end
        else if (cmd.fill)
        begin
            source_reg   <= mask_reg[part_rd_reg[PART_W-1:0]] ? SRC_LOCAL : SRC_REMOTE;
            slot_reg     <= SLOT_OUT_W'(cur_reg);
            part_out_reg <= part_rd_reg[PART_W-1:0];
            lidx_out_reg <= lidx_rd_reg;
            ev_valid_reg <= evict_reg;
            ev_node_reg  <= evict_reg ? owner_rd_reg : '0;
        end
    end

    always_comb
    begin
        slots_next     = slots_reg;
        mask_next      = mask_reg;
        clr_cnt_next   = clr_cnt_reg;
        next_slot_next = next_slot_reg;
        out_valid_next = out_valid_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_SLOTS_IN_USE: slots_next = cfg_data[SLOTS_W-1:0];
                REG_LOCAL_MASK:   mask_next  = cfg_data[MASK_W-1:0];
                default:          slots_next = slots_reg;
            endcase
        end
        if (cmd.clr_en)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.fill)
        begin
            next_slot_next = (LIM_W'(cur_inc) >= lim) ? '0 : cur_inc[SLOT_AW-1:0];
        end
        if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fill || cmd.out_short)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= SLOTS_RESET;
            mask_reg      <= MASK_RESET;
            clr_cnt_reg   <= '0;
            next_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg     <= slots_next;
            mask_reg      <= mask_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_slot_reg <= next_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign source          = source_reg;
    assign slot            = slot_reg;
    assign partition_out   = part_out_reg;
    assign local_index_out = lidx_out_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_node    = ev_node_reg;

endmodule
